[hdl/assert_macros.svh]
// Assertion macros for the RTL that carries concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define OTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// next-cycle implication, disabled during reset
`define OTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons on next cycle");

`endif

[hdl/ota_crc_pkg.sv]
// Types, codes and constants for the OTA image CRC-32 verifier.
// No dependencies; used by every module of the block.
package ota_crc_pkg;

    localparam int TRAILER_LEN = 7;
    localparam int CRC_BYTES   = 4;
    localparam int WIN_LEN     = TRAILER_LEN + CRC_BYTES;
    localparam int CNT_W       = 21;
    localparam int CFG_W       = 21;
    localparam int CRC_W       = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [CFG_W-1:0] MAX_BODY_RESET  = 21'd1044480;
    localparam logic [CFG_W-1:0] BUF_LIMIT_RESET = 21'd1048576;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_END    = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_OK       = 2'd1,
        VERDICT_LEN_FAIL = 2'd2,
        VERDICT_CRC_BAD  = 2'd3
    } verdict_t;

    typedef enum logic {
        REG_MAX_BODY_LEN = 1'b0,
        REG_BUFFER_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]       verdict;
        logic             overflow_flag;
        logic [CNT_W-1:0] body_length;
        logic [CRC_W-1:0] computed_crc;
        logic [CNT_W-1:0] bytes_received;
    } result_t;

    typedef struct packed {
        logic  fire;
        item_t item;
    } step_t;

    typedef struct packed {
        logic session_active;
        logic overflowed;
    } status_t;

endpackage

[hdl/ota_crc_unit.sv]
// Byte-wide reflected CRC-32 update, fully unrolled over eight bit steps.
// Depends on ota_crc_pkg.
module ota_crc_unit (
    input  logic [ota_crc_pkg::CRC_W-1:0] crc_in,
    input  logic [7:0]                    data,
    output logic [ota_crc_pkg::CRC_W-1:0] crc_out
);

    always_comb
    begin
        logic [ota_crc_pkg::CRC_W-1:0] c;
        c = crc_in ^ {{(ota_crc_pkg::CRC_W-8){1'b0}}, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = ota_crc_pkg::CRC_POLY ^ (c >> 1);
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

[hdl/ota_crc_core.sv]
// Session state, tail window, running CRC and result formation per word.
// Depends on ota_crc_pkg and ota_crc_unit.
module ota_crc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ota_crc_pkg::CFG_W-1:0] cfg_data,
    input  ota_crc_pkg::step_t            step,
    output ota_crc_pkg::result_t          result_next,
    output ota_crc_pkg::status_t          status
);

    localparam int CNT_W = ota_crc_pkg::CNT_W;
    localparam int WIN_LEN = ota_crc_pkg::WIN_LEN;

    logic [ota_crc_pkg::CFG_W-1:0] max_body_reg;
    logic [ota_crc_pkg::CFG_W-1:0] buf_limit_reg;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          active_reg, active_next;
    logic                          ovf_reg, ovf_next;
    logic [7:0]                    win_reg [WIN_LEN];
    logic [7:0]                    win_next [WIN_LEN];
    logic [ota_crc_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic [ota_crc_pkg::CRC_W-1:0] crc_upd;

    logic [CNT_W-1:0]              body_bytes;
    logic [ota_crc_pkg::CRC_W-1:0] crc_final;
    logic [ota_crc_pkg::CRC_W-1:0] crc_expect;
    logic                          len_fail;

    ota_crc_unit u_crc (
        .crc_in  (crc_reg),
        .data    (win_reg[0]),
        .crc_out (crc_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg  <= ota_crc_pkg::MAX_BODY_RESET;
            buf_limit_reg <= ota_crc_pkg::BUF_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ota_crc_pkg::REG_MAX_BODY_LEN: max_body_reg  <= cfg_data;
                ota_crc_pkg::REG_BUFFER_LIMIT: buf_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // finish evaluation on the stored state
    always_comb
    begin
        body_bytes = count_reg - CNT_W'(WIN_LEN);
        crc_final  = crc_reg ^ ota_crc_pkg::CRC_ONES;
        crc_expect = {win_reg[3], win_reg[2], win_reg[1], win_reg[0]};
        len_fail   = ovf_reg || (count_reg <= CNT_W'(WIN_LEN)) || (body_bytes > max_body_reg);
    end

    always_comb
    begin
        count_next = count_reg;
        active_next = active_reg;
        ovf_next = ovf_reg;
        crc_next = crc_reg;
        for (int i = 0; i < WIN_LEN; i++)
            win_next[i] = win_reg[i];

        if (step.fire)
        begin
            case (step.item.command)
                ota_crc_pkg::CMD_START:
                begin
                    active_next = 1'b1;
                    ovf_next = 1'b0;
                    count_next = '0;
                    crc_next = ota_crc_pkg::CRC_ONES;
                    for (int i = 0; i < WIN_LEN; i++)
                        win_next[i] = '0;
                end
                ota_crc_pkg::CMD_DATA:
                begin
                    if (active_reg)
                    begin
                        if (count_reg >= buf_limit_reg)
                        begin
                            ovf_next = 1'b1;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            if (count_reg >= CNT_W'(WIN_LEN))
                                crc_next = crc_upd;
                            for (int i = 0; i < WIN_LEN - 1; i++)
                                win_next[i] = win_reg[i+1];
                            win_next[WIN_LEN-1] = step.item.data_byte;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                ota_crc_pkg::CMD_END:
                    active_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result_next = '0;
        result_next.overflow_flag = ovf_next;
        result_next.bytes_received = count_next;
        if (step.item.command == ota_crc_pkg::CMD_FINISH)
        begin
            if (len_fail)
                result_next.verdict = ota_crc_pkg::VERDICT_LEN_FAIL;
            else
            begin
                result_next.body_length = body_bytes;
                result_next.computed_crc = crc_final;
                result_next.verdict = (crc_final == crc_expect) ?
                                      ota_crc_pkg::VERDICT_OK :
                                      ota_crc_pkg::VERDICT_CRC_BAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            active_reg <= 1'b0;
            ovf_reg <= 1'b0;
            crc_reg <= ota_crc_pkg::CRC_ONES;
            for (int i = 0; i < WIN_LEN; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            count_reg <= count_next;
            active_reg <= active_next;
            ovf_reg <= ovf_next;
            crc_reg <= crc_next;
            for (int i = 0; i < WIN_LEN; i++)
                win_reg[i] <= win_next[i];
        end
    end

    assign status.session_active = active_reg;
    assign status.overflowed = ovf_reg;

endmodule

[hdl/ota_image_crc32_verifier.sv]
// OTA image CRC-32 verifier, top level: word handshake and result register.
// An accepted word's result word is registered and valid in the cycle after acceptance.
// Throughput: one word per cycle while no finished word is held back by result_stall.
// Reset (rst_n, async low): session idle, count and flags clear, CRC all ones,
// registers at their defaults. Depends on ota_crc_pkg, ota_crc_core, assert_macros.svh.
`include "assert_macros.svh"

module ota_image_crc32_verifier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ota_crc_pkg::CFG_W-1:0] cfg_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  ota_crc_pkg::item_t            item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ota_crc_pkg::result_t          result
);

    ota_crc_pkg::step_t   step;
    ota_crc_pkg::result_t result_next;
    ota_crc_pkg::result_t result_reg;
    ota_crc_pkg::status_t status;
    logic                 valid_reg;
    logic                 len_fail_word;
    logic                 empty_payload;

    // hold input only while a finished word waits downstream
    assign item_stall = valid_reg && result_stall;
    assign step.fire = item_valid && !item_stall;
    assign step.item = item;

    ota_crc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (step),
        .result_next (result_next),
        .status      (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step.fire)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step.fire)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result = result_reg;

    assign len_fail_word = result_valid && (result.verdict == ota_crc_pkg::VERDICT_LEN_FAIL);
    assign empty_payload = (result.body_length == '0) && (result.computed_crc == '0);

    `OTA_ASSERT_IMP(a_stall_when_full, clk, rst_n, result_valid && result_stall, item_stall)
    `OTA_ASSERT_NEXT(a_fire_gives_word, clk, rst_n, item_valid && !item_stall, result_valid)
    `OTA_ASSERT_IMP(a_ovf_ends_session, clk, rst_n, status.overflowed, !status.session_active)
    `OTA_ASSERT_IMP(a_len_fail_zero, clk, rst_n, len_fail_word, empty_payload)

endmodule
